// File: sv/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, letter codes and digit pattern function for the Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_V    = 8'h56;
   localparam logic [7:0] CHAR_X    = 8'h58;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_M    = 8'h4D;
   localparam logic [7:0] CHAR_NONE = 8'h00;

   localparam int unsigned MAX_CHARS = 15;
   localparam logic [11:0] MAX_VALID = 12'd3999;

   typedef struct packed {
      logic       err;
      logic [1:0] thousands;
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   typedef struct packed {
      logic [31:0] chars;
      logic [2:0]  len;
   } pat_type;

   typedef struct packed {
      logic                     err;
      logic [MAX_CHARS*8-1:0]   chars;
      logic [3:0]               len;
   } numeral_type;

   // letters of one decimal digit, first letter in the low byte
   function automatic pat_type digit_pat(input logic [3:0] d, input logic [7:0] one,
                                         input logic [7:0] five, input logic [7:0] ten);
      pat_type p;
      p.chars = '0;
      p.len   = 3'd0;
      case (d)
         4'd0: begin
            p.len = 3'd0;
         end
         4'd1: begin
            p.chars = {24'h0, one};
            p.len   = 3'd1;
         end
         4'd2: begin
            p.chars = {16'h0, one, one};
            p.len   = 3'd2;
         end
         4'd3: begin
            p.chars = {8'h0, one, one, one};
            p.len   = 3'd3;
         end
         4'd4: begin
            p.chars = {16'h0, five, one};
            p.len   = 3'd2;
         end
         4'd5: begin
            p.chars = {24'h0, five};
            p.len   = 3'd1;
         end
         4'd6: begin
            p.chars = {16'h0, one, five};
            p.len   = 3'd2;
         end
         4'd7: begin
            p.chars = {8'h0, one, one, five};
            p.len   = 3'd3;
         end
         4'd8: begin
            p.chars = {one, one, one, five};
            p.len   = 3'd4;
         end
         4'd9: begin
            p.chars = {16'h0, ten, one};
            p.len   = 3'd2;
         end
         default: begin
            p.chars = '0;
            p.len   = 3'd0;
         end
      endcase
      return p;
   endfunction

endpackage

// File: sv/rne_digits.sv
// ----------------------------------------------------------------------------
// rne_digits
// Three register stages that split the value into thousands, hundreds, tens
// and ones digits by constant compares and subtracts, and flag bad values.
// ----------------------------------------------------------------------------
module rne_digits (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [11:0]         in_value,
   output logic                out_valid,
   input  logic                out_ready,
   output rne_pkg::digits_type out_digits
);
   import rne_pkg::*;

   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic       adv1, adv2, adv3;

   logic       s1_err_ff, s1_err_in;
   logic [1:0] s1_th_ff, s1_th_in;
   logic [9:0] s1_rem_ff, s1_rem_in;

   logic       s2_err_ff;
   logic [1:0] s2_th_ff;
   logic [3:0] s2_h_ff, s2_h_in;
   logic [6:0] s2_rem_ff, s2_rem_in;

   digits_type s3_dig_ff, s3_dig_in;

   logic [11:0] th_sub;
   logic [9:0]  h_sub;
   logic [6:0]  t_sub;
   logic [3:0]  t_dig;

   assign adv3     = !s3_valid_ff || out_ready;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // thousands
   always_comb begin
      s1_err_in = (in_value == 12'd0) || (in_value > MAX_VALID);
      if (in_value >= 12'd3000) begin
         s1_th_in = 2'd3;
      end else if (in_value >= 12'd2000) begin
         s1_th_in = 2'd2;
      end else if (in_value >= 12'd1000) begin
         s1_th_in = 2'd1;
      end else begin
         s1_th_in = 2'd0;
      end
      th_sub    = 12'(s1_th_in) * 12'd1000;
      s1_rem_in = 10'(in_value - th_sub);
   end

   // hundreds
   always_comb begin
      s2_h_in = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (s1_rem_ff >= 10'(k * 100)) begin
            s2_h_in = 4'(k);
         end
      end
      h_sub     = 10'(s2_h_in) * 10'd100;
      s2_rem_in = 7'(s1_rem_ff - h_sub);
   end

   // tens and ones
   always_comb begin
      t_dig = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (s2_rem_ff >= 7'(k * 10)) begin
            t_dig = 4'(k);
         end
      end
      t_sub               = 7'(t_dig) * 7'd10;
      s3_dig_in.err       = s2_err_ff;
      s3_dig_in.thousands = s2_th_ff;
      s3_dig_in.hundreds  = s2_h_ff;
      s3_dig_in.tens      = t_dig;
      s3_dig_in.ones      = 4'(s2_rem_ff - t_sub);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= in_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_err_ff <= s1_err_in;
         s1_th_ff  <= s1_th_in;
         s1_rem_ff <= s1_rem_in;
      end
      if (adv2) begin
         s2_err_ff <= s1_err_ff;
         s2_th_ff  <= s1_th_ff;
         s2_h_ff   <= s2_h_in;
         s2_rem_ff <= s2_rem_in;
      end
      if (adv3) begin
         s3_dig_ff <= s3_dig_in;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_digits = s3_dig_ff;

endmodule

// File: sv/rne_pattern.sv
// ----------------------------------------------------------------------------
// rne_pattern
// Three register stages that turn the digits into letter groups and merge
// them into one left-aligned run of up to fifteen letters.
// ----------------------------------------------------------------------------
module rne_pattern (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rne_pkg::digits_type  in_digits,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rne_pkg::numeral_type out_numeral
);
   import rne_pkg::*;

   logic s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic adv4, adv5, adv6;

   logic        s4_err_ff, s4_err_in;
   logic [23:0] s4_thc_ff, s4_thc_in;
   logic [1:0]  s4_thl_ff, s4_thl_in;
   pat_type     s4_h_ff, s4_h_in;
   pat_type     s4_t_ff, s4_t_in;
   pat_type     s4_o_ff, s4_o_in;

   logic        s5_err_ff;
   logic [55:0] s5_ac_ff, s5_ac_in;
   logic [2:0]  s5_al_ff, s5_al_in;
   logic [63:0] s5_bc_ff, s5_bc_in;
   logic [3:0]  s5_bl_ff, s5_bl_in;

   numeral_type s6_num_ff, s6_num_in;

   assign adv6     = !s6_valid_ff || out_ready;
   assign adv5     = !s5_valid_ff || adv6;
   assign adv4     = !s4_valid_ff || adv5;
   assign in_ready = adv4;

   // letter groups per place
   always_comb begin
      s4_err_in = in_digits.err;
      case (in_digits.thousands)
         2'd1: begin
            s4_thc_in = {16'h0, CHAR_M};
            s4_thl_in = 2'd1;
         end
         2'd2: begin
            s4_thc_in = {8'h0, CHAR_M, CHAR_M};
            s4_thl_in = 2'd2;
         end
         2'd3: begin
            s4_thc_in = {CHAR_M, CHAR_M, CHAR_M};
            s4_thl_in = 2'd3;
         end
         default: begin
            s4_thc_in = '0;
            s4_thl_in = 2'd0;
         end
      endcase
      s4_h_in = digit_pat(in_digits.hundreds, CHAR_C, CHAR_D, CHAR_M);
      s4_t_in = digit_pat(in_digits.tens, CHAR_X, CHAR_L, CHAR_C);
      s4_o_in = digit_pat(in_digits.ones, CHAR_I, CHAR_V, CHAR_X);
      // bad value: one null letter
      if (in_digits.err) begin
         s4_thc_in = {16'h0, CHAR_NONE};
         s4_thl_in = 2'd1;
         s4_h_in   = '0;
         s4_t_in   = '0;
         s4_o_in   = '0;
      end
   end

   // pairwise merge
   always_comb begin
      s5_ac_in = 56'(s4_thc_ff) | (56'(s4_h_ff.chars) << {s4_thl_ff, 3'b000});
      s5_al_in = 3'(s4_thl_ff) + s4_h_ff.len;
      s5_bc_in = 64'(s4_t_ff.chars) | (64'(s4_o_ff.chars) << {s4_t_ff.len, 3'b000});
      s5_bl_in = 4'(s4_t_ff.len) + 4'(s4_o_ff.len);
   end

   // final merge
   always_comb begin
      s6_num_in.err   = s5_err_ff;
      s6_num_in.chars = (MAX_CHARS*8)'(s5_ac_ff)
                      | ((MAX_CHARS*8)'(s5_bc_ff) << {s5_al_ff, 3'b000});
      s6_num_in.len   = 4'(s5_al_ff) + s5_bl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (adv4) begin
            s4_valid_ff <= in_valid;
         end
         if (adv5) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (adv6) begin
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_err_ff <= s4_err_in;
         s4_thc_ff <= s4_thc_in;
         s4_thl_ff <= s4_thl_in;
         s4_h_ff   <= s4_h_in;
         s4_t_ff   <= s4_t_in;
         s4_o_ff   <= s4_o_in;
      end
      if (adv5) begin
         s5_err_ff <= s4_err_ff;
         s5_ac_ff  <= s5_ac_in;
         s5_al_ff  <= s5_al_in;
         s5_bc_ff  <= s5_bc_in;
         s5_bl_ff  <= s5_bl_in;
      end
      if (adv6) begin
         s6_num_ff <= s6_num_in;
      end
   end

   assign out_valid   = s6_valid_ff;
   assign out_numeral = s6_num_ff;

endmodule

// File: sv/rne_serial.sv
// ----------------------------------------------------------------------------
// rne_serial
// Output shifter that sends one letter per cycle and loads the next numeral
// in the cycle of the previous one's last letter.
// ----------------------------------------------------------------------------
module rne_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rne_pkg::numeral_type in_numeral,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_char_code,
   output logic                 rsp_last,
   output logic                 rsp_out_of_range
);
   import rne_pkg::*;

   logic [MAX_CHARS*8-1:0] sbuf_ff, sbuf_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic                   err_ff, err_in;
   logic                   load;

   assign in_ready = (cnt_ff <= 4'd1);
   assign load     = in_valid && in_ready;

   always_comb begin
      sbuf_in = sbuf_ff;
      cnt_in  = cnt_ff;
      err_in  = err_ff;
      if (load) begin
         sbuf_in = in_numeral.chars;
         cnt_in  = in_numeral.len;
         err_in  = in_numeral.err;
      end else if (cnt_ff != 4'd0) begin
         sbuf_in = {8'h00, sbuf_ff[MAX_CHARS*8-1:8]};
         cnt_in  = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sbuf_ff <= sbuf_in;
      err_ff  <= err_in;
   end

   assign rsp_valid        = (cnt_ff != 4'd0);
   assign rsp_char_code    = sbuf_ff[7:0];
   assign rsp_last         = (cnt_ff == 4'd1);
   assign rsp_out_of_range = err_ff;

endmodule

// File: sv/roman_numeral_encoder_top.sv
// the first letter shows once the value is through the pipeline and the shifter
// throughput: one letter per cycle; a numeral of n letters (1 to 15) holds the
// output shifter until its last letter, when the next numeral can load
// the six-stage digit and pattern pipeline takes a new value every cycle
// while it has room; busy rises when the output shifter backs it up
// reset (synchronous) empties the pipeline and the output shifter
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Converts a 12-bit value to Roman numeral letters, one per cycle, with the
// final letter marked and bad values flagged.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last,
   output logic        rsp_out_of_range
);
   import rne_pkg::*;

   logic        dig_ready;
   logic        dig_valid;
   logic        pat_ready;
   digits_type  digits;
   logic        num_valid;
   logic        ser_ready;
   numeral_type numeral;

   assign busy = !dig_ready;

   rne_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_ready   (dig_ready),
      .in_value   (req_value),
      .out_valid  (dig_valid),
      .out_ready  (pat_ready),
      .out_digits (digits)
   );

   rne_pattern u_pattern (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dig_valid),
      .in_ready    (pat_ready),
      .in_digits   (digits),
      .out_valid   (num_valid),
      .out_ready   (ser_ready),
      .out_numeral (numeral)
   );

   rne_serial u_serial (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (num_valid),
      .in_ready         (ser_ready),
      .in_numeral       (numeral),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

// File: test/roman_numeral_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top_tb
// Drives values into the Roman numeral encoder and checks every letter that
// comes out against a predicted numeral. A short directed run covers the range
// ends, out-of-range values and the subtractive digits. A random run with
// random sender gaps and a drain pause halfway through follows.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rne_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 310;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned TAIL_CYCLES  = 20;

   typedef struct {
      logic [7:0] char_code;
      logic       last;
      logic       out_of_range;
   } letter_type;

   class numeral_scoreboard;
      letter_type  expected_letters[$];
      logic [7:0]  numeral[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void add_digit(int unsigned d, logic [7:0] one, logic [7:0] five,
                              logic [7:0] ten);
         int unsigned rest;
         rest = d;
         case (d)
            4: begin
               numeral.push_back(one);
               numeral.push_back(five);
            end
            9: begin
               numeral.push_back(one);
               numeral.push_back(ten);
            end
            default: begin
               if (rest >= 5) begin
                  numeral.push_back(five);
                  rest = rest - 5;
               end
               repeat (rest) numeral.push_back(one);
            end
         endcase
      endfunction

      function void note_value(logic [11:0] value);
         letter_type  l;
         int unsigned v;
         v = int'(value);
         numeral.delete();
         if (v == 0 || v > int'(MAX_VALID)) begin
            l.char_code    = CHAR_NONE;
            l.last         = 1'b1;
            l.out_of_range = 1'b1;
            expected_letters.push_back(l);
         end else begin
            repeat (v / 1000) numeral.push_back(CHAR_M);
            add_digit((v % 1000) / 100, CHAR_C, CHAR_D, CHAR_M);
            add_digit((v % 100) / 10, CHAR_X, CHAR_L, CHAR_C);
            add_digit(v % 10, CHAR_I, CHAR_V, CHAR_X);
            foreach (numeral[i]) begin
               l.char_code    = numeral[i];
               l.last         = (i == numeral.size() - 1);
               l.out_of_range = 1'b0;
               expected_letters.push_back(l);
            end
         end
      endfunction

      function void check_letter(logic [7:0] char_code, logic last, logic out_of_range);
         letter_type e;
         if (expected_letters.size() == 0) begin
            $error("unexpected result: char_code %0h last %0b out_of_range %0b",
                   char_code, last, out_of_range);
            mismatches++;
         end else begin
            e = expected_letters.pop_front();
            if (char_code !== e.char_code) begin
               $error("char_code: expected %0h, got %0h", e.char_code, char_code);
               mismatches++;
            end
            if (last !== e.last) begin
               $error("last: expected %0b, got %0b", e.last, last);
               mismatches++;
            end
            if (out_of_range !== e.out_of_range) begin
               $error("out_of_range: expected %0b, got %0b", e.out_of_range, out_of_range);
               mismatches++;
            end
         end
      endfunction

      function int unsigned pending();
         return expected_letters.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_value;
   logic        rsp_valid;
   logic [7:0]  rsp_char_code;
   logic        rsp_last;
   logic        rsp_out_of_range;

   numeral_scoreboard numerals;
   int unsigned       stall_cycles;

   logic [11:0] directed_values [24] = '{
      12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
      12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd2000, 12'd3000, 12'd5,
      12'd50, 12'd500, 12'd1994, 12'd444, 12'd999, 12'd3, 12'd8, 12'd2730
   };

   roman_numeral_encoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // transfers on both sides, plus the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            numerals.check_letter(rsp_char_code, rsp_last, rsp_out_of_range);
         if (start && !busy)
            numerals.note_value(req_value);
         if (rsp_valid || (start && !busy)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic send_value(logic [11:0] value);
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start     <= 1'b0;
         req_value <= 12'($urandom);
      end
   endtask

   task automatic drain_numerals();
      idle_cycles(1);
      while (numerals.pending() != 0) @(posedge clock);
   endtask

   function automatic int unsigned random_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [11:0] random_value();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 6) return 12'd0;
      if (sel < 14) return 12'($urandom_range(4000, 4095));
      if (sel < 22) return 12'($urandom);
      return 12'($urandom_range(1, 3999));
   endfunction

   initial begin
      bit no_gaps;
      numerals     = new();
      stall_cycles = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) begin
         send_value(directed_values[i]);
         idle_cycles(i % 3);
      end
      drain_numerals();

      no_gaps = 1'b0;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            no_gaps = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_ITEMS / 2)
            drain_numerals();
         send_value(random_value());
         if (!no_gaps)
            idle_cycles(random_gap());
      end

      drain_numerals();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (numerals.mismatches == 0 && numerals.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
